// ----- hdl/four_d_point_rotator_assert.svh -----
// ---------------------------------------------------------------------------
// four_d_point_rotator assertion macros
// shared concurrent assertion forms, sampled on clock and disabled in reset
// ---------------------------------------------------------------------------
`ifndef FOUR_D_POINT_ROTATOR_ASSERT_SVH
`define FOUR_D_POINT_ROTATOR_ASSERT_SVH

// same-cycle implication
`define FDR_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("fdr assertion failed");

// next-cycle implication
`define FDR_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("fdr assertion failed");

`endif

// ----- hdl/fdr_pkg.sv -----
// ---------------------------------------------------------------------------
// fdr_pkg
// types, constants and the sine / cosine table of the 4d point rotator
// ---------------------------------------------------------------------------
`default_nettype none

package fdr_pkg;

   localparam int COORD_W     = 24;
   localparam int COORD_COUNT = 4;
   localparam int STEP_W      = 8;
   localparam int STAGE_COUNT = 6;
   localparam int INDEX_W     = 3;
   localparam int TRIG_FRAC   = 16;
   localparam int TRIG_W      = TRIG_FRAC + 2;
   localparam int PROD_W      = COORD_W + TRIG_W;
   localparam int SUM_W       = PROD_W + 1;
   localparam int STEP_MAG_MAX = 1 << (STEP_W - 1);
   localparam int ROM_ENTRY_W = 2 * TRIG_W;
   localparam int ROM_DEPTH   = STEP_MAG_MAX + 1;
   localparam int ROM_BITS    = ROM_DEPTH * ROM_ENTRY_W;
   localparam int COORD_MAX   = (1 << (COORD_W - 1)) - 1;
   localparam int COORD_MIN   = -(1 << (COORD_W - 1));
   localparam int ROUND_HALF  = 1 << (TRIG_FRAC - 1);

   // pi / 3600 in q48
   localparam logic [63:0] ANGLE_K48 = 64'd245633255279;

   localparam logic [1:0] COORD_X = 2'd0;
   localparam logic [1:0] COORD_Y = 2'd1;
   localparam logic [1:0] COORD_Z = 2'd2;
   localparam logic [1:0] COORD_W_IDX = 2'd3;

   localparam logic [STAGE_COUNT-1:0][1:0] STAGE_A =
      {COORD_Z, COORD_Y, COORD_Y, COORD_X, COORD_X, COORD_X};
   localparam logic [STAGE_COUNT-1:0][1:0] STAGE_B =
      {COORD_W_IDX, COORD_W_IDX, COORD_Z, COORD_W_IDX, COORD_Z, COORD_Y};

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef coord_type [COORD_COUNT-1:0] point_type;

   typedef struct packed {
      point_type point;
      logic      clipped;
   } stage_data_type;

   typedef struct packed {
      logic signed [TRIG_W-1:0] cosine;
      logic signed [TRIG_W-1:0] sine;
   } trig_pair_type;

   typedef trig_pair_type [STAGE_COUNT-1:0] trig_bank_type;

   // cosine (upper half) and sine (lower half) magnitudes for each step size
   function automatic logic [ROM_BITS-1:0] build_trig_rom();
      logic [ROM_BITS-1:0] rom;
      logic [63:0] th, t2, t3, t4, t5, t6, s31, c31, sv, cv;
      int m;
      rom = '0;
      for (m = 0; m < ROM_DEPTH; m++) begin
         th  = (64'(m) * ANGLE_K48 + 64'd65536) >> 17;
         t2  = (th * th + (64'd1 << 30)) >> 31;
         t3  = (t2 * th + (64'd1 << 30)) >> 31;
         t5  = (t3 * t2 + (64'd1 << 30)) >> 31;
         t4  = (t2 * t2 + (64'd1 << 30)) >> 31;
         t6  = (t4 * t2 + (64'd1 << 30)) >> 31;
         s31 = th - (t3 + 64'd3) / 6 + (t5 + 64'd60) / 120;
         c31 = (64'd1 << 31) - (t2 + 64'd1) / 2 + (t4 + 64'd12) / 24
               - (t6 + 64'd360) / 720;
         sv  = (s31 + (64'd1 << (30 - TRIG_FRAC))) >> (31 - TRIG_FRAC);
         cv  = (c31 + (64'd1 << (30 - TRIG_FRAC))) >> (31 - TRIG_FRAC);
         rom[m*ROM_ENTRY_W +: ROM_ENTRY_W] = {cv[TRIG_W-1:0], sv[TRIG_W-1:0]};
      end
      return rom;
   endfunction

   localparam logic [ROM_BITS-1:0] TRIG_ROM = build_trig_rom();

endpackage

`default_nettype wire

// ----- hdl/fdr_trig_regs.sv -----
// ---------------------------------------------------------------------------
// fdr_trig_regs
// per-stage cosine / sine registers, loaded from the table on a csr write
// ---------------------------------------------------------------------------
`default_nettype none

module fdr_trig_regs
   import fdr_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_we,
   input  wire logic [INDEX_W-1:0] csr_index,
   input  wire logic [STEP_W-1:0]  csr_wdata,
   output trig_bank_type           trig
);

   trig_bank_type            trig_ff;
   trig_pair_type            pair_in;
   logic [STEP_W-1:0]        step_mag;
   logic [ROM_ENTRY_W-1:0]   rom_entry;
   logic signed [TRIG_W-1:0] sine_mag;

   always_comb begin
      step_mag  = csr_wdata[STEP_W-1] ? (~csr_wdata + 1'b1) : csr_wdata;
      rom_entry = TRIG_ROM[step_mag*ROM_ENTRY_W +: ROM_ENTRY_W];
      sine_mag  = rom_entry[TRIG_W-1:0];
      pair_in.cosine = rom_entry[ROM_ENTRY_W-1:TRIG_W];
      pair_in.sine   = csr_wdata[STEP_W-1] ? -sine_mag : sine_mag;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < STAGE_COUNT; k++) begin
            trig_ff[k].cosine <= TRIG_W'(1 << TRIG_FRAC);
            trig_ff[k].sine   <= '0;
         end
      end else if (csr_we && (32'(csr_index) < STAGE_COUNT)) begin
         trig_ff[csr_index] <= pair_in;
      end
   end

   assign trig = trig_ff;

endmodule

`default_nettype wire

// ----- hdl/fdr_plane_stage.sv -----
// ---------------------------------------------------------------------------
// fdr_plane_stage
// one plane rotation: a multiply register, then sum, round and clamp register
// ---------------------------------------------------------------------------
`default_nettype none

`include "four_d_point_rotator_assert.svh"

module fdr_plane_stage
   import fdr_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic [1:0]     plane_a,
   input  wire logic [1:0]     plane_b,
   input  wire trig_pair_type  trig,
   input  wire logic           in_valid,
   output logic                in_ready,
   input  wire stage_data_type in_data,
   output logic                out_valid,
   input  wire logic           out_ready,
   output stage_data_type      out_data
);

   typedef struct packed {
      stage_data_type           data;
      logic signed [PROD_W-1:0] ac;
      logic signed [PROD_W-1:0] bs;
      logic signed [PROD_W-1:0] as;
      logic signed [PROD_W-1:0] bc;
   } mul_data_type;

   mul_data_type   mul_ff, mul_in;
   logic           mul_valid_ff;
   logic           mul_ready;
   stage_data_type out_ff, out_in;
   logic           out_valid_ff;

   logic signed [COORD_W-1:0] coord_a, coord_b;
   logic signed [SUM_W-1:0]   sum_a, sum_b, shr_a, shr_b;
   logic signed [COORD_W-1:0] res_a, res_b;
   logic                      clip_a, clip_b;

   function automatic logic [COORD_W:0] clamp_coord(input logic signed [SUM_W-1:0] v);
      logic [COORD_W:0] r;
      if (v > SUM_W'(COORD_MAX)) begin
         r = {1'b1, COORD_W'(COORD_MAX)};
      end else if (v < SUM_W'(COORD_MIN)) begin
         r = {1'b1, COORD_W'(COORD_MIN)};
      end else begin
         r = {1'b0, v[COORD_W-1:0]};
      end
      return r;
   endfunction

   assign mul_ready = !out_valid_ff || out_ready;
   assign in_ready  = !mul_valid_ff || mul_ready;

   // products
   always_comb begin
      coord_a     = $signed(in_data.point[plane_a]);
      coord_b     = $signed(in_data.point[plane_b]);
      mul_in.data = in_data;
      mul_in.ac   = PROD_W'(coord_a) * PROD_W'(trig.cosine);
      mul_in.bs   = PROD_W'(coord_b) * PROD_W'(trig.sine);
      mul_in.as   = PROD_W'(coord_a) * PROD_W'(trig.sine);
      mul_in.bc   = PROD_W'(coord_b) * PROD_W'(trig.cosine);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
      end else if (in_ready) begin
         mul_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         mul_ff <= mul_in;
      end
   end

   // sum, round to nearest, saturate
   always_comb begin
      sum_a = SUM_W'(mul_ff.ac) - SUM_W'(mul_ff.bs) + SUM_W'(ROUND_HALF);
      sum_b = SUM_W'(mul_ff.as) + SUM_W'(mul_ff.bc) + SUM_W'(ROUND_HALF);
      shr_a = sum_a >>> TRIG_FRAC;
      shr_b = sum_b >>> TRIG_FRAC;
      {clip_a, res_a} = clamp_coord(shr_a);
      {clip_b, res_b} = clamp_coord(shr_b);
      out_in = mul_ff.data;
      out_in.point[plane_a] = res_a;
      out_in.point[plane_b] = res_b;
      out_in.clipped = mul_ff.data.clipped | clip_a | clip_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (mul_ready) begin
         out_valid_ff <= mul_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mul_ready && mul_valid_ff) begin
         out_ff <= out_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_ff;

   `FDR_ASSERT_NEXT(a_mul_held, mul_valid_ff && !mul_ready, mul_valid_ff)
   `FDR_ASSERT_NEXT(a_mul_moves, mul_valid_ff && mul_ready, out_valid_ff)
   `FDR_ASSERT_NEXT(a_clip_kept, mul_valid_ff && mul_ready && mul_ff.data.clipped,
                    out_ff.clipped)

endmodule

`default_nettype wire

// ----- hdl/four_d_point_rotator.sv -----
// ---------------------------------------------------------------------------
// four_d_point_rotator
// rotates a signed q15.8 4d point through the xy, xz, xw, yz, yw, zw planes
// ---------------------------------------------------------------------------
// usage
//   req_* carries one point per transaction (valid / ready), rsp_* returns the
//   rotated point and a flag that is set when any plane stage saturated.
//   csr_we writes the step of stage csr_index (0 to 5, others ignored) as
//   8-bit signed 0.05 degree units; the cosine / sine pair is looked up from a
//   table in the same cycle. write only while no transaction is in flight.
//   structure: two register stages per plane (product register, then sum /
//   round / clamp register).
//   throughput: one point per cycle while rsp_ready is high; each register
//   stage holds one point and takes a new one as it hands its last one on.
//   reset: pipeline emptied, every stage set to cosine one, sine zero.
//   stall: when rsp_ready is low the output holds; earlier stages keep filling
//   empty slots, and req_ready falls once every stage holds a point.
// ---------------------------------------------------------------------------
`default_nettype none

module four_d_point_rotator
   import fdr_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic signed [COORD_W-1:0] req_in_x,
   input  wire logic signed [COORD_W-1:0] req_in_y,
   input  wire logic signed [COORD_W-1:0] req_in_z,
   input  wire logic signed [COORD_W-1:0] req_in_w,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic signed [COORD_W-1:0]      rsp_out_x,
   output logic signed [COORD_W-1:0]      rsp_out_y,
   output logic signed [COORD_W-1:0]      rsp_out_z,
   output logic signed [COORD_W-1:0]      rsp_out_w,
   output logic                           rsp_clipped,
   input  wire logic                      csr_we,
   input  wire logic [INDEX_W-1:0]        csr_index,
   input  wire logic [STEP_W-1:0]         csr_wdata
);

   trig_bank_type  trig;
   logic           link_valid [STAGE_COUNT+1];
   logic           link_ready [STAGE_COUNT+1];
   stage_data_type link_data  [STAGE_COUNT+1];

   fdr_trig_regs u_trig_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .trig      (trig)
   );

   always_comb begin
      link_data[0].point[COORD_X]     = req_in_x;
      link_data[0].point[COORD_Y]     = req_in_y;
      link_data[0].point[COORD_Z]     = req_in_z;
      link_data[0].point[COORD_W_IDX] = req_in_w;
      link_data[0].clipped            = 1'b0;
   end

   assign link_valid[0] = req_valid;
   assign req_ready     = link_ready[0];

   for (genvar k = 0; k < STAGE_COUNT; k++) begin : g_stage
      fdr_plane_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .plane_a   (STAGE_A[k]),
         .plane_b   (STAGE_B[k]),
         .trig      (trig[k]),
         .in_valid  (link_valid[k]),
         .in_ready  (link_ready[k]),
         .in_data   (link_data[k]),
         .out_valid (link_valid[k+1]),
         .out_ready (link_ready[k+1]),
         .out_data  (link_data[k+1])
      );
   end

   assign link_ready[STAGE_COUNT] = rsp_ready;
   assign rsp_valid   = link_valid[STAGE_COUNT];
   assign rsp_out_x   = link_data[STAGE_COUNT].point[COORD_X];
   assign rsp_out_y   = link_data[STAGE_COUNT].point[COORD_Y];
   assign rsp_out_z   = link_data[STAGE_COUNT].point[COORD_Z];
   assign rsp_out_w   = link_data[STAGE_COUNT].point[COORD_W_IDX];
   assign rsp_clipped = link_data[STAGE_COUNT].clipped;

endmodule

`default_nettype wire

// ----- dv/tb_four_d_point_rotator.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_four_d_point_rotator
// self-checking bench for the six-plane 4d point rotator: a short list of
// directed points and turn settings, then about four hundred random points
// over eight turn settings with varying back-pressure on both channels.
// every response is checked field by field against a listed expected value or
// an in-bench model of the stage trigonometry, rounding and saturation.
// ---------------------------------------------------------------------------

module tb_four_d_point_rotator;
   import fdr_pkg::*;

   typedef enum logic [INDEX_W-1:0] {
      TURN_XY, TURN_XZ, TURN_XW, TURN_YZ, TURN_YW, TURN_ZW, TURN_SPARE6, TURN_SPARE7
   } turn_index_type;

   typedef enum logic [1:0] {ROW_KNOWN, ROW_PREDICT, ROW_SETTING} row_kind_type;

   typedef struct {
      coord_type x, y, z, w;
      logic      clipped;
   } rotated_type;

   typedef struct {
      row_kind_type kind;
      int           v [STAGE_COUNT];
      int           want [COORD_COUNT];
      logic         want_clip;
   } dir_row_type;

   localparam int STEP_MAX         = 127;
   localparam int STEP_MIN         = -128;
   localparam int PIPE_LATENCY     = 12;
   localparam int DRAIN_GAP        = PIPE_LATENCY + 4;
   localparam int STALL_LIMIT      = 1000;
   localparam int HOLD_CYCLES      = 200;
   localparam int ROUNDS           = 8;
   localparam int POINTS_PER_ROUND = 50;
   localparam int HOLD_ROUND       = 4;
   localparam int IDLE_HALF        = 50;
   localparam int IDLE_QUARTER     = 25;

   localparam logic [1:0] MIX_A [STAGE_COUNT] =
      '{COORD_X, COORD_X, COORD_X, COORD_Y, COORD_Y, COORD_Z};
   localparam logic [1:0] MIX_B [STAGE_COUNT] =
      '{COORD_Y, COORD_Z, COORD_W_IDX, COORD_Z, COORD_W_IDX, COORD_W_IDX};

   logic      clock = 1'b0;
   logic      reset;
   logic      req_valid;
   logic      req_ready;
   coord_type req_in_x, req_in_y, req_in_z, req_in_w;
   logic      rsp_valid;
   logic      rsp_ready = 1'b0;
   coord_type rsp_out_x, rsp_out_y, rsp_out_z, rsp_out_w;
   logic      rsp_clipped;
   logic                 csr_we;
   logic [INDEX_W-1:0]   csr_index;
   logic [STEP_W-1:0]    csr_wdata;

   rotated_type rotated_due [$];
   longint      stage_cos [STAGE_COUNT];
   longint      stage_sin [STAGE_COUNT];
   int          send_pct;
   int          recv_pct;
   int          error_count;
   logic        rsp_held;
   event        hold_kick;

   dir_row_type directed_rows [21] = '{
      '{ROW_KNOWN,   '{0, 0, 0, 0, 0, 0}, '{0, 0, 0, 0}, 1'b0},
      '{ROW_KNOWN,   '{COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 0, 0},
                     '{COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX}, 1'b0},
      '{ROW_KNOWN,   '{COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, 0, 0},
                     '{COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN}, 1'b0},
      '{ROW_KNOWN,   '{COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, 0, 0},
                     '{COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN}, 1'b0},
      '{ROW_KNOWN,   '{1, -1, 256, -256, 0, 0}, '{1, -1, 256, -256}, 1'b0},
      '{ROW_SETTING, '{STEP_MAX, STEP_MAX, STEP_MAX, STEP_MAX, STEP_MAX, STEP_MAX},
                     '{0, 0, 0, 0}, 1'b0},
      '{ROW_KNOWN,   '{0, 0, 0, 0, 0, 0}, '{0, 0, 0, 0}, 1'b0},
      '{ROW_PREDICT, '{COORD_MAX, COORD_MAX, 0, 0, 0, 0}, '{0, 0, 0, 0}, 1'b0},
      '{ROW_PREDICT, '{COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 0, 0},
                     '{0, 0, 0, 0}, 1'b0},
      '{ROW_PREDICT, '{COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, 0, 0},
                     '{0, 0, 0, 0}, 1'b0},
      '{ROW_PREDICT, '{256, 0, 0, 0, 0, 0}, '{0, 0, 0, 0}, 1'b0},
      '{ROW_SETTING, '{STEP_MIN, STEP_MIN, STEP_MIN, STEP_MIN, STEP_MIN, STEP_MIN},
                     '{0, 0, 0, 0}, 1'b0},
      '{ROW_PREDICT, '{COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, 0, 0},
                     '{0, 0, 0, 0}, 1'b0},
      '{ROW_PREDICT, '{COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, 0, 0},
                     '{0, 0, 0, 0}, 1'b0},
      '{ROW_PREDICT, '{0, 0, 0, 256, 0, 0}, '{0, 0, 0, 0}, 1'b0},
      '{ROW_SETTING, '{1, -1, 0, 64, -64, STEP_MAX}, '{0, 0, 0, 0}, 1'b0},
      '{ROW_PREDICT, '{COORD_MAX, 0, COORD_MIN, 1, 0, 0}, '{0, 0, 0, 0}, 1'b0},
      '{ROW_PREDICT, '{-1, 1, -1, 1, 0, 0}, '{0, 0, 0, 0}, 1'b0},
      '{ROW_SETTING, '{0, 0, 0, 0, 0, 0}, '{0, 0, 0, 0}, 1'b0},
      '{ROW_KNOWN,   '{COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 0, 0},
                     '{COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX}, 1'b0},
      '{ROW_KNOWN,   '{-1, 0, 1, COORD_MIN, 0, 0}, '{-1, 0, 1, COORD_MIN}, 1'b0}
   };

   four_d_point_rotator uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_in_x    (req_in_x),
      .req_in_y    (req_in_y),
      .req_in_z    (req_in_z),
      .req_in_w    (req_in_w),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_out_x   (rsp_out_x),
      .rsp_out_y   (rsp_out_y),
      .rsp_out_z   (rsp_out_z),
      .rsp_out_w   (rsp_out_w),
      .rsp_clipped (rsp_clipped),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // angle arithmetic in unsigned q33.31
   function automatic logic [63:0] q31_mul(logic [63:0] a, logic [63:0] b);
      return (a * b + (64'd1 << 30)) >> 31;
   endfunction

   function automatic logic [63:0] div_near(logic [63:0] a, logic [63:0] d);
      return (a + d / 2) / d;
   endfunction

   function automatic longint to_trig_frac(logic [63:0] v);
      return longint'((v + (64'd1 << (30 - TRIG_FRAC))) >> (31 - TRIG_FRAC));
   endfunction

   task automatic set_stage_trig(int stage, logic signed [STEP_W-1:0] step);
      logic [63:0] mag, th, t2, t3, t4, t5, t6, s31, c31;
      longint      sine_mag;
      mag = (step < 0) ? 64'(-longint'(step)) : 64'(longint'(step));
      th  = (mag * ANGLE_K48 + 64'd65536) >> 17;
      t2  = q31_mul(th, th);
      t3  = q31_mul(t2, th);
      t5  = q31_mul(t3, t2);
      t4  = q31_mul(t2, t2);
      t6  = q31_mul(t4, t2);
      s31 = th - div_near(t3, 6) + div_near(t5, 120);
      c31 = (64'd1 << 31) - div_near(t2, 2) + div_near(t4, 24) - div_near(t6, 720);
      sine_mag = to_trig_frac(s31);
      stage_cos[stage] = to_trig_frac(c31);
      stage_sin[stage] = (step < 0) ? -sine_mag : sine_mag;
   endtask

   function automatic longint clip_coord(longint v, inout logic hit);
      if (v > COORD_MAX) begin
         hit = 1'b1;
         return COORD_MAX;
      end
      if (v < COORD_MIN) begin
         hit = 1'b1;
         return COORD_MIN;
      end
      return v;
   endfunction

   function automatic rotated_type rotate_point(coord_type x, coord_type y, coord_type z,
                                                coord_type w);
      longint      p [COORD_COUNT];
      longint      a, b, na, nb;
      int          k;
      rotated_type r;
      p[COORD_X]     = x;
      p[COORD_Y]     = y;
      p[COORD_Z]     = z;
      p[COORD_W_IDX] = w;
      r.clipped = 1'b0;
      for (k = 0; k < STAGE_COUNT; k++) begin
         a  = p[MIX_A[k]];
         b  = p[MIX_B[k]];
         na = (a * stage_cos[k] - b * stage_sin[k] + ROUND_HALF) >>> TRIG_FRAC;
         nb = (a * stage_sin[k] + b * stage_cos[k] + ROUND_HALF) >>> TRIG_FRAC;
         p[MIX_A[k]] = clip_coord(na, r.clipped);
         p[MIX_B[k]] = clip_coord(nb, r.clipped);
      end
      r.x = coord_type'(p[COORD_X]);
      r.y = coord_type'(p[COORD_Y]);
      r.z = coord_type'(p[COORD_Z]);
      r.w = coord_type'(p[COORD_W_IDX]);
      return r;
   endfunction

   function automatic coord_type pick_coord();
      int unsigned sel;
      sel = $urandom_range(0, 9);
      if (sel < 4)
         return coord_type'($urandom);
      if (sel < 6) begin
         case ($urandom_range(0, 4))
            0: begin
               return coord_type'(COORD_MAX);
            end
            1: begin
               return coord_type'(COORD_MIN);
            end
            2: begin
               return coord_type'(0);
            end
            3: begin
               return coord_type'(1);
            end
            default: begin
               return coord_type'(-1);
            end
         endcase
      end
      return coord_type'(int'($urandom_range(0, 131071)) - 65536);
   endfunction

   function automatic int pick_step();
      case ($urandom_range(0, 9))
         0: begin
            return STEP_MAX;
         end
         1: begin
            return STEP_MIN;
         end
         2: begin
            return 0;
         end
         default: begin
            return int'($urandom_range(0, 255)) - 128;
         end
      endcase
   endfunction

   task automatic report_mismatch(string what, coord_type got, coord_type want);
      $display("%0t: %s mismatch, got %0d want %0d", $realtime, what, got, want);
      error_count++;
   endtask

   // writes all six turns, then junk into the two unused indices
   task automatic load_turns(int steps [STAGE_COUNT]);
      int i;
      for (i = TURN_XY; i <= TURN_ZW; i++) begin
         csr_we    <= 1'b1;
         csr_index <= i[INDEX_W-1:0];
         csr_wdata <= steps[i][STEP_W-1:0];
         @(posedge clock);
         set_stage_trig(i, steps[i][STEP_W-1:0]);
      end
      csr_index <= TURN_SPARE6;
      csr_wdata <= STEP_W'($urandom_range(1, 255));
      @(posedge clock);
      csr_index <= TURN_SPARE7;
      csr_wdata <= STEP_W'($urandom_range(1, 255));
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic offer_point(coord_type x, coord_type y, coord_type z, coord_type w,
                              logic known, rotated_type known_r);
      rotated_type due_r;
      while ($urandom_range(0, 99) < send_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_in_x  <= x;
      req_in_y  <= y;
      req_in_z  <= z;
      req_in_w  <= w;
      due_r = known ? known_r : rotate_point(x, y, z, w);
      do @(posedge clock); while (!req_ready);
      rotated_due.insert(rotated_due.size(), due_r);
   endtask

   task automatic drain_pipe();
      req_valid <= 1'b0;
      while (rotated_due.size() != 0)
         @(posedge clock);
      repeat (DRAIN_GAP) @(posedge clock);
   endtask

   always @(posedge clock) begin : rsp_check
      rotated_type head;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (rotated_due.size() == 0) begin
               report_mismatch("unrequested transaction, out_x", rsp_out_x, 0);
            end else begin
               head = rotated_due.pop_front();
               if (rsp_out_x !== head.x) report_mismatch("out_x", rsp_out_x, head.x);
               if (rsp_out_y !== head.y) report_mismatch("out_y", rsp_out_y, head.y);
               if (rsp_out_z !== head.z) report_mismatch("out_z", rsp_out_z, head.z);
               if (rsp_out_w !== head.w) report_mismatch("out_w", rsp_out_w, head.w);
               if (rsp_clipped !== head.clipped)
                  report_mismatch("clipped", rsp_clipped, head.clipped);
            end
         end
         rsp_ready <= !rsp_held && ($urandom_range(0, 99) >= recv_pct);
      end
   end

   // long receiver hold-off so the pipeline fills and back-pressures
   initial begin : rsp_hold
      rsp_held = 1'b0;
      @(hold_kick);
      rsp_held <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_held <= 1'b0;
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("tb_four_d_point_rotator: done, errors");
      $finish;
   end

   initial begin : stimulus
      dir_row_type row;
      rotated_type known_r;
      int          steps [STAGE_COUNT];
      int          n, k, round;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_in_x    = '0;
      req_in_y    = '0;
      req_in_z    = '0;
      req_in_w    = '0;
      csr_we      = 1'b0;
      csr_index   = TURN_XY;
      csr_wdata   = '0;
      send_pct    = 0;
      recv_pct    = 0;
      error_count = 0;
      for (k = 0; k < STAGE_COUNT; k++) begin
         stage_cos[k] = longint'(1) << TRIG_FRAC;
         stage_sin[k] = 0;
      end
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (n = 0; n < $size(directed_rows); n++) begin
         row = directed_rows[n];
         if (row.kind == ROW_SETTING) begin
            drain_pipe();
            load_turns(row.v);
         end else begin
            known_r.x       = coord_type'(row.want[COORD_X]);
            known_r.y       = coord_type'(row.want[COORD_Y]);
            known_r.z       = coord_type'(row.want[COORD_Z]);
            known_r.w       = coord_type'(row.want[COORD_W_IDX]);
            known_r.clipped = row.want_clip;
            offer_point(coord_type'(row.v[COORD_X]), coord_type'(row.v[COORD_Y]),
                        coord_type'(row.v[COORD_Z]), coord_type'(row.v[COORD_W_IDX]),
                        row.kind == ROW_KNOWN, known_r);
         end
      end

      for (round = 0; round < ROUNDS; round++) begin
         drain_pipe();
         for (k = 0; k < STAGE_COUNT; k++) begin
            case (round)
               0: begin
                  steps[k] = STEP_MAX;
               end
               1: begin
                  steps[k] = STEP_MIN;
               end
               2: begin
                  steps[k] = 0;
               end
               default: begin
                  steps[k] = pick_step();
               end
            endcase
         end
         load_turns(steps);
         case (round % 4)
            0: begin
               send_pct = 0;
               recv_pct = 0;
            end
            1: begin
               send_pct = IDLE_HALF;
               recv_pct = 0;
            end
            2: begin
               send_pct = 0;
               recv_pct = IDLE_HALF;
            end
            default: begin
               send_pct = IDLE_QUARTER;
               recv_pct = IDLE_QUARTER;
            end
         endcase
         if (round == HOLD_ROUND)
            -> hold_kick;
         repeat (POINTS_PER_ROUND)
            offer_point(pick_coord(), pick_coord(), pick_coord(), pick_coord(), 1'b0, known_r);
      end

      drain_pipe();
      if (error_count == 0)
         $display("tb_four_d_point_rotator: done, clean");
      else
         $display("tb_four_d_point_rotator: done, errors");
      $finish;
   end

endmodule

// ----- four_d_point_rotator.f -----
+incdir+hdl
hdl/fdr_pkg.sv
hdl/fdr_trig_regs.sv
hdl/fdr_plane_stage.sv
hdl/four_d_point_rotator.sv
dv/tb_four_d_point_rotator.sv
